// ----- rtl/input_restricted_deque_top_assert.svh -----
`ifndef INPUT_RESTRICTED_DEQUE_TOP_ASSERT_SVH
`define INPUT_RESTRICTED_DEQUE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IRD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define IRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ird_pkg.sv -----
package ird_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_REAR = 2'd2,
        CMD_DUMP = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHOW
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_ENQ,
        DP_FULL,
        DP_EMPTY,
        DP_DEQ,
        DP_REAR,
        DP_DUMP_START,
        DP_DUMP_NEXT,
        DP_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic dump_more;
    } dp_stat_t;

    // base + off modulo DEPTH; base < DEPTH and off <= DEPTH keep the sum below 2*DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ----- rtl/ird_cmd_if.sv -----
interface ird_cmd_if;
    logic                                valid;
    logic                                ready;
    ird_pkg::cmd_t                       command;
    logic signed [ird_pkg::WORD_W-1:0]   value;

    modport source (output valid, output command, output value, input ready);
    modport sink (input valid, input command, input value, output ready);
endinterface

// ----- rtl/ird_res_if.sv -----
interface ird_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [ird_pkg::WORD_W-1:0]   value_res;
    ird_pkg::status_t                    status;
    logic                                last;
    logic                                now_empty;

    modport source (output valid, output value_res, output status, output last,
                    output now_empty, input ready);
    modport sink (input valid, input value_res, input status, input last,
                  input now_empty, output ready);
endinterface

// ----- rtl/input_restricted_deque_top.sv -----
// Bounded deque of signed 32-bit words in a 16-entry ring store (registered-read RAM),
// with words entering at the rear and leaving from the front or rear. One command is
// handled at a time. Enqueue and empty/full reports go from accept straight to the
// result beat; dequeue and remove-rear pass through a read state for the RAM read.
// A dump gives one RAM read and one result beat per word, with last set on the
// final beat; an empty queue answers every removal or dump with a single empty beat.
// Each result beat is held until it is taken. The store needs no clearing after reset.
module input_restricted_deque_top (
    input  logic       clk,
    input  logic       rst_n,
    ird_cmd_if.sink    request,
    ird_res_if.source  response
);

    ird_pkg::dp_ctrl_t dp_ctrl;
    ird_pkg::dp_stat_t dp_stat;

    ird_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .command   (request.command),
        .out_valid (response.valid),
        .out_ready (response.ready),
        .dp_stat   (dp_stat),
        .dp_ctrl   (dp_ctrl)
    );

    ird_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_ctrl   (dp_ctrl),
        .dp_stat   (dp_stat),
        .value     (request.value),
        .value_res (response.value_res),
        .status    (response.status),
        .last      (response.last),
        .now_empty (response.now_empty)
    );

endmodule

// ----- rtl/ird_ram.sv -----
module ird_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ird_ctrl.sv -----
module ird_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ird_pkg::cmd_t     command,
    output logic              out_valid,
    input  logic              out_ready,
    input  ird_pkg::dp_stat_t dp_stat,
    output ird_pkg::dp_ctrl_t dp_ctrl
);

    ird_pkg::state_t state_reg;
    ird_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ird_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        dp_ctrl.op = ird_pkg::DP_NOP;
        case (state_reg)
            ird_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (command)
                        ird_pkg::CMD_ENQ:
                        begin
                            dp_ctrl.op = dp_stat.full ? ird_pkg::DP_FULL : ird_pkg::DP_ENQ;
                            state_next = ird_pkg::S_SHOW;
                        end
                        ird_pkg::CMD_DEQ:
                        begin
                            dp_ctrl.op = dp_stat.empty ? ird_pkg::DP_EMPTY : ird_pkg::DP_DEQ;
                            state_next = dp_stat.empty ? ird_pkg::S_SHOW : ird_pkg::S_READ;
                        end
                        ird_pkg::CMD_REAR:
                        begin
                            dp_ctrl.op = dp_stat.empty ? ird_pkg::DP_EMPTY : ird_pkg::DP_REAR;
                            state_next = dp_stat.empty ? ird_pkg::S_SHOW : ird_pkg::S_READ;
                        end
                        ird_pkg::CMD_DUMP:
                        begin
                            dp_ctrl.op = dp_stat.empty ? ird_pkg::DP_EMPTY
                                                       : ird_pkg::DP_DUMP_START;
                            state_next = dp_stat.empty ? ird_pkg::S_SHOW : ird_pkg::S_READ;
                        end
                        default:
                        begin
                            state_next = ird_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            ird_pkg::S_READ:
            begin
                dp_ctrl.op = ird_pkg::DP_LOAD;
                state_next = ird_pkg::S_SHOW;
            end
            ird_pkg::S_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (dp_stat.dump_more)
                    begin
                        dp_ctrl.op = ird_pkg::DP_DUMP_NEXT;
                        state_next = ird_pkg::S_READ;
                    end
                    else
                    begin
                        state_next = ird_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ird_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/ird_datapath.sv -----
`include "input_restricted_deque_top_assert.svh"

module ird_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ird_pkg::dp_ctrl_t                 dp_ctrl,
    output ird_pkg::dp_stat_t                 dp_stat,
    input  logic signed [ird_pkg::WORD_W-1:0] value,
    output logic signed [ird_pkg::WORD_W-1:0] value_res,
    output ird_pkg::status_t                  status,
    output logic                              last,
    output logic                              now_empty
);

    logic [ird_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [ird_pkg::IDX_W-1:0]  front_reg, front_next;
    logic [ird_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                       dump_reg, dump_next;
    logic                       last_reg, last_next;
    logic                       now_empty_reg, now_empty_next;
    ird_pkg::status_t           status_reg, status_next;
    logic signed [ird_pkg::WORD_W-1:0] value_res_reg, value_res_next;

    logic                       ram_we;
    logic                       ram_re;
    logic [ird_pkg::IDX_W-1:0]  ram_waddr;
    logic [ird_pkg::IDX_W-1:0]  ram_raddr;
    logic [ird_pkg::WORD_W-1:0] ram_rdata;
    logic [ird_pkg::CNT_W-1:0]  idx_inc;
    logic                       count_one;

    ird_ram #(
        .WIDTH (ird_pkg::WORD_W),
        .DEPTH (ird_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_inc   = ird_pkg::CNT_W'(idx_reg) + ird_pkg::CNT_W'(1);
    assign count_one = (count_reg == ird_pkg::CNT_W'(1));

    always_comb
    begin
        count_next     = count_reg;
        front_next     = front_reg;
        idx_next       = idx_reg;
        dump_next      = dump_reg;
        last_next      = last_reg;
        now_empty_next = now_empty_reg;
        status_next    = status_reg;
        value_res_next = value_res_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = ird_pkg::ring_add(front_reg, count_reg);
        ram_raddr      = front_reg;
        case (dp_ctrl.op)
            ird_pkg::DP_ENQ:
            begin
                ram_we         = 1'b1;
                count_next     = count_reg + ird_pkg::CNT_W'(1);
                value_res_next = '0;
                status_next    = ird_pkg::ST_OK;
                last_next      = 1'b1;
                now_empty_next = 1'b0;
                dump_next      = 1'b0;
            end
            ird_pkg::DP_FULL:
            begin
                value_res_next = '0;
                status_next    = ird_pkg::ST_FULL;
                last_next      = 1'b1;
                now_empty_next = 1'b0;
                dump_next      = 1'b0;
            end
            ird_pkg::DP_EMPTY:
            begin
                value_res_next = '0;
                status_next    = ird_pkg::ST_EMPTY;
                last_next      = 1'b1;
                now_empty_next = 1'b1;
                dump_next      = 1'b0;
            end
            ird_pkg::DP_DEQ:
            begin
                ram_re         = 1'b1;
                front_next     = ird_pkg::ring_add(front_reg, ird_pkg::CNT_W'(1));
                count_next     = count_reg - ird_pkg::CNT_W'(1);
                status_next    = ird_pkg::ST_OK;
                last_next      = 1'b1;
                now_empty_next = count_one;
                dump_next      = 1'b0;
            end
            ird_pkg::DP_REAR:
            begin
                ram_re         = 1'b1;
                ram_raddr      = ird_pkg::ring_add(front_reg, count_reg - ird_pkg::CNT_W'(1));
                count_next     = count_reg - ird_pkg::CNT_W'(1);
                if (count_one)
                begin
                    front_next = '0;
                end
                status_next    = ird_pkg::ST_OK;
                last_next      = 1'b1;
                now_empty_next = count_one;
                dump_next      = 1'b0;
            end
            ird_pkg::DP_DUMP_START:
            begin
                ram_re         = 1'b1;
                idx_next       = '0;
                status_next    = ird_pkg::ST_OK;
                last_next      = count_one;
                now_empty_next = 1'b0;
                dump_next      = 1'b1;
            end
            ird_pkg::DP_DUMP_NEXT:
            begin
                ram_re         = 1'b1;
                ram_raddr      = ird_pkg::ring_add(front_reg, idx_inc);
                idx_next       = idx_inc[ird_pkg::IDX_W-1:0];
                last_next      = ((idx_inc + ird_pkg::CNT_W'(1)) == count_reg);
            end
            ird_pkg::DP_LOAD:
            begin
                value_res_next = $signed(ram_rdata);
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            front_reg <= '0;
            dump_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            front_reg <= front_next;
            dump_reg  <= dump_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        now_empty_reg <= now_empty_next;
        status_reg    <= status_next;
        value_res_reg <= value_res_next;
    end

    assign dp_stat.empty     = (count_reg == '0);
    assign dp_stat.full      = (count_reg >= ird_pkg::CNT_W'(ird_pkg::DEPTH));
    assign dp_stat.dump_more = dump_reg && !last_reg;

    assign value_res = value_res_reg;
    assign status    = status_reg;
    assign last      = last_reg;
    assign now_empty = now_empty_reg;

    `IRD_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= ird_pkg::CNT_W'(ird_pkg::DEPTH), "count above depth")
    `IRD_ASSERT_NEXT(a_enq_grows, dp_ctrl.op == ird_pkg::DP_ENQ, count_reg == ird_pkg::CNT_W'($past(count_reg) + 1'b1), "enqueue did not add one")
    `IRD_ASSERT_NEXT(a_full_holds, dp_ctrl.op == ird_pkg::DP_FULL, $stable(count_reg) && $stable(front_reg), "full report changed state")
    `IRD_ASSERT_NEXT(a_remove_empty_flag, dp_ctrl.op == ird_pkg::DP_DEQ || dp_ctrl.op == ird_pkg::DP_REAR, now_empty_reg == (count_reg == '0), "now_empty disagrees with count")

endmodule

// ----- bench/tb_input_restricted_deque_top.sv -----
`timescale 1ns / 1ps

module tb_input_restricted_deque_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 100;

    typedef struct packed {
        logic signed [ird_pkg::WORD_W-1:0] value_res;
        ird_pkg::status_t                  status;
        logic                              last;
        logic                              now_empty;
    } deque_beat_t;

    class deque_scoreboard;
        logic [ird_pkg::WORD_W-1:0] words [ird_pkg::DEPTH];
        logic [ird_pkg::IDX_W-1:0]  front;
        logic [ird_pkg::CNT_W-1:0]  count;
        deque_beat_t                pending_beats [$];
        int                         mismatches;

        function new();
            front = '0;
            count = '0;
            mismatches = 0;
            foreach (words[i])
            begin
                words[i] = '0;
            end
        endfunction

        function logic [ird_pkg::IDX_W-1:0] slot(input int offset);
            return ird_pkg::IDX_W'((int'(front) + offset) % ird_pkg::DEPTH);
        endfunction

        function void push_beat(input logic [ird_pkg::WORD_W-1:0] v,
                                input ird_pkg::status_t s,
                                input logic l, input logic e);
            deque_beat_t b;
            b.value_res = v;
            b.status = s;
            b.last = l;
            b.now_empty = e;
            pending_beats.push_back(b);
        endfunction

        function int outstanding();
            return pending_beats.size();
        endfunction

        function void note_command(input ird_pkg::cmd_t c,
                                   input logic [ird_pkg::WORD_W-1:0] v);
            logic [ird_pkg::WORD_W-1:0] got;
            if (c == ird_pkg::CMD_ENQ)
            begin
                if (int'(count) >= ird_pkg::DEPTH)
                begin
                    push_beat('0, ird_pkg::ST_FULL, 1'b1, 1'b0);
                end
                else
                begin
                    words[slot(int'(count))] = v;
                    count = count + 1'b1;
                    push_beat('0, ird_pkg::ST_OK, 1'b1, 1'b0);
                end
            end
            else if (count == 0)
            begin
                push_beat('0, ird_pkg::ST_EMPTY, 1'b1, 1'b1);
            end
            else if (c == ird_pkg::CMD_DEQ)
            begin
                got = words[front];
                front = slot(1);
                count = count - 1'b1;
                push_beat(got, ird_pkg::ST_OK, 1'b1, count == 0);
            end
            else if (c == ird_pkg::CMD_REAR)
            begin
                got = words[slot(int'(count) - 1)];
                count = count - 1'b1;
                if (count == 0)
                begin
                    front = '0;
                end
                push_beat(got, ird_pkg::ST_OK, 1'b1, count == 0);
            end
            else
            begin
                for (int i = 0; i < int'(count); i++)
                begin
                    push_beat(words[slot(i)], ird_pkg::ST_OK, i + 1 == int'(count), 1'b0);
                end
            end
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(input logic signed [ird_pkg::WORD_W-1:0] v,
                          input ird_pkg::status_t s,
                          input logic l, input logic e);
            deque_beat_t want;
            if (pending_beats.size() == 0)
            begin
                report($sformatf("unexpected beat value=%0d status=%0d", v, s));
                return;
            end
            want = pending_beats.pop_front();
            if (v !== want.value_res)
            begin
                report($sformatf("value_res %0d, want %0d", v, want.value_res));
            end
            if (s !== want.status)
            begin
                report($sformatf("status %0d, want %0d", s, want.status));
            end
            if (l !== want.last)
            begin
                report($sformatf("last %0b, want %0b", l, want.last));
            end
            if (e !== want.now_empty)
            begin
                report($sformatf("now_empty %0b, want %0b", e, want.now_empty));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_stall_pct;
    bit   hold_req;
    bit   fill_mode;

    ird_cmd_if cmd_ch ();
    ird_res_if res_ch ();

    deque_scoreboard sb;

    input_restricted_deque_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (cmd_ch),
        .response (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            sb.check_result(res_ch.value_res, res_ch.status, res_ch.last,
                            res_ch.now_empty);
        end
    end

    task send_cmd(input ird_pkg::cmd_t c, input logic [ird_pkg::WORD_W-1:0] v);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= c;
        cmd_ch.value   <= v;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_command(c, v);
    endtask

    task wait_drained();
        cmd_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function ird_pkg::cmd_t pick_cmd();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
        begin
            return ird_pkg::cmd_t'($urandom_range(0, 3));
        end
        if (roll < 25)
        begin
            return ird_pkg::CMD_DUMP;
        end
        if (fill_mode)
        begin
            return (roll < 80) ? ird_pkg::CMD_ENQ
                               : (roll < 90 ? ird_pkg::CMD_DEQ : ird_pkg::CMD_REAR);
        end
        return (roll < 45) ? ird_pkg::CMD_ENQ
                           : (roll < 72 ? ird_pkg::CMD_DEQ : ird_pkg::CMD_REAR);
    endfunction

    task random_item();
        if (int'(sb.count) == ird_pkg::DEPTH)
        begin
            fill_mode = 1'b0;
        end
        else if (sb.count == 0)
        begin
            fill_mode = 1'b1;
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            fill_mode = ~fill_mode;
        end
        send_cmd(pick_cmd(), $urandom);
    endtask

    initial
    begin
        sb = new();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b0;
        fill_mode    = 1'b1;
        rst_n          <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= ird_pkg::CMD_ENQ;
        cmd_ch.value   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue on every removal and on dump
        send_cmd(ird_pkg::CMD_DEQ, 32'h1234_5678);
        send_cmd(ird_pkg::CMD_REAR, '1);
        send_cmd(ird_pkg::CMD_DUMP, '0);
        send_cmd(ird_pkg::CMD_ENQ, 32'h8000_0000);
        send_cmd(ird_pkg::CMD_ENQ, 32'h7FFF_FFFF);
        send_cmd(ird_pkg::CMD_ENQ, 32'h0000_0000);
        send_cmd(ird_pkg::CMD_ENQ, 32'hFFFF_FFFF);
        send_cmd(ird_pkg::CMD_DUMP, '0);
        send_cmd(ird_pkg::CMD_REAR, '0);
        send_cmd(ird_pkg::CMD_DEQ, '0);
        while (int'(sb.count) < ird_pkg::DEPTH)
        begin
            send_cmd(ird_pkg::CMD_ENQ, $urandom);
        end
        // full: word dropped
        send_cmd(ird_pkg::CMD_ENQ, 32'h5A5A_A5A5);
        send_cmd(ird_pkg::CMD_DUMP, '0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 47; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 47; end
                default: begin tx_idle_pct = 28; rx_stall_pct = 28; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 0 && n == 40)
                begin
                    hold_req = 1'b1;
                end
                if (phase == 1 && n == 50)
                begin
                    wait_drained();
                end
                random_item();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
